[rtl/quaternion_vector_rotation_defines.svh]
// Assertion macros for the quaternion rotation block.
// Both sample on the rising edge of clk and are disabled while rst is high.
`ifndef QUATERNION_VECTOR_ROTATION_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATION_DEFINES_SVH

// Same-cycle implication
`define QVR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qvr: assertion failed");

// Next-cycle implication
`define QVR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qvr: assertion failed");

`endif

[rtl/qvr_pkg.sv]
`default_nettype none

package qvr_pkg;

  // Field widths
  localparam int QW  = 18;          // quaternion component, Q1.16
  localparam int CW  = 32;          // coordinate, Q16.16
  localparam int HW  = CW / 2;      // coordinate half word

  // Datapath widths
  localparam int PW  = 2 * QW;      // quaternion product
  localparam int MW  = PW + 2;      // rotation matrix entry
  localparam int PHW = MW + HW;     // matrix entry times signed upper half
  localparam int PLW = MW + HW + 1; // matrix entry times unsigned lower half
  localparam int SHW = PHW + 2;     // row sum of upper-half products
  localparam int SLW = PLW + 2;     // row sum of lower-half products
  localparam int AW  = SHW + HW;    // full row dot product, units 2^-48
  localparam int RW  = AW - CW;     // rounded row result before clipping

  localparam logic signed [QW-1:0] QUAT_ONE   = QW'(65536);
  localparam logic signed [AW-1:0] ROUND_HALF =
    {{(AW - CW){1'b0}}, 1'b1, {(CW - 1){1'b0}}};
  localparam logic signed [CW-1:0] COORD_MAX  = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN  = {1'b1, {(CW - 1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_QUAT_X = 2'd0,
    REG_QUAT_Y = 2'd1,
    REG_QUAT_Z = 2'd2,
    REG_QUAT_W = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
    logic signed [CW-1:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic                 saturated;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/quaternion_vector_rotation.sv]
// Quaternion rotation of a stream of 3D points (Q16.16) by q (Q1.16 components).
// Output is the vector part of q * v * conj(q), scaled by |q|^2 as q is not
// normalized, rounded to nearest (ties up) and clipped to 32 bits per axis.
// Input channel in_valid/in_stall/in_data, output channel out_valid/out_stall/
// out_data; a transaction happens on a clock edge with valid high, stall low.
// Config: cfg_wen writes cfg_data[17:0] into the register chosen by cfg_index
// (x, y, z, w). Write while no transaction is in flight and at least one
// clock before the next input transaction; a write passes through the q
// registers and the quadratic-term registers before it reaches the matrix.
// Throughput: one point per clock while out_stall is low. A point passes
// through six register stages (input, split, multiply, row sums, round,
// clip/output) on its way from the input transaction to out_valid.
// Stall: the output register holds while out_stall is high; bubbles inside
// are filled first, then in_stall rises once every stage holds a point.
// Reset (rst, synchronous) empties the pipeline and sets q to identity.
`default_nettype none
`include "quaternion_vector_rotation_defines.svh"

module quaternion_vector_rotation
  import qvr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  // configuration
  input  wire logic      cfg_wen,
  input  wire cfg_reg_t  cfg_index,
  input  wire logic [QW-1:0] cfg_data,
  // input points
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  // rotated points
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  // Configuration registers
  logic signed [QW-1:0] quat_x, quat_y, quat_z, quat_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_x <= '0;
      quat_y <= '0;
      quat_z <= '0;
      quat_w <= QUAT_ONE;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_QUAT_X: quat_x <= cfg_data;
        REG_QUAT_Y: quat_y <= cfg_data;
        REG_QUAT_Z: quat_z <= cfg_data;
        REG_QUAT_W: quat_w <= cfg_data;
        default: ;
      endcase
    end
  end

  // Quadratic terms of q
  logic signed [PW-1:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;

  always_ff @(posedge clk) begin
    p_ww <= quat_w * quat_w;
    p_xx <= quat_x * quat_x;
    p_yy <= quat_y * quat_y;
    p_zz <= quat_z * quat_z;
    p_xy <= quat_x * quat_y;
    p_xz <= quat_x * quat_z;
    p_yz <= quat_y * quat_z;
    p_wx <= quat_w * quat_x;
    p_wy <= quat_w * quat_y;
    p_wz <= quat_w * quat_z;
  end

  // Rotation matrix, units 2^-32
  logic signed [MW-1:0] mat [3][3];

  always_ff @(posedge clk) begin
    mat[0][0] <= MW'(p_ww) + MW'(p_xx) - MW'(p_yy) - MW'(p_zz);
    mat[0][1] <= (MW'(p_xy) - MW'(p_wz)) <<< 1;
    mat[0][2] <= (MW'(p_xz) + MW'(p_wy)) <<< 1;
    mat[1][0] <= (MW'(p_xy) + MW'(p_wz)) <<< 1;
    mat[1][1] <= MW'(p_ww) - MW'(p_xx) + MW'(p_yy) - MW'(p_zz);
    mat[1][2] <= (MW'(p_yz) - MW'(p_wx)) <<< 1;
    mat[2][0] <= (MW'(p_xz) - MW'(p_wy)) <<< 1;
    mat[2][1] <= (MW'(p_yz) + MW'(p_wx)) <<< 1;
    mat[2][2] <= MW'(p_ww) - MW'(p_xx) - MW'(p_yy) + MW'(p_zz);
  end

  // Pipeline stage registers
  logic                  v1_valid, v2_valid, v3_valid, v4_valid, v5_valid;
  in_item_t              v1;
  logic signed [CW-1:0]  vin [3];
  logic signed [HW-1:0]  hi2 [3];
  logic signed [HW:0]    lo2 [3];
  logic signed [PHW-1:0] ph3 [3][3];
  logic signed [PLW-1:0] pl3 [3][3];
  logic signed [SHW-1:0] sh4 [3];
  logic signed [SLW-1:0] sl4 [3];
  logic signed [AW-1:0]  acc [3];
  logic signed [RW-1:0]  r5  [3];
  logic signed [CW-1:0]  clip [3];
  logic [2:0]            clipped;
  logic                  at_limit;
  logic                  pipe_blocked;

  // Stage ready chain: a stage loads when empty or when it drains this cycle
  logic rdy_o, rdy5, rdy4, rdy3, rdy2, rdy1;

  always_comb begin
    rdy_o    = !out_valid || !out_stall;
    rdy5     = !v5_valid || rdy_o;
    rdy4     = !v4_valid || rdy5;
    rdy3     = !v3_valid || rdy4;
    rdy2     = !v2_valid || rdy3;
    rdy1     = !v1_valid || rdy2;
    in_stall = !rdy1;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1_valid  <= 1'b0;
      v2_valid  <= 1'b0;
      v3_valid  <= 1'b0;
      v4_valid  <= 1'b0;
      v5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1)  v1_valid  <= in_valid;
      if (rdy2)  v2_valid  <= v1_valid;
      if (rdy3)  v3_valid  <= v2_valid;
      if (rdy4)  v4_valid  <= v3_valid;
      if (rdy5)  v5_valid  <= v4_valid;
      if (rdy_o) out_valid <= v5_valid;
    end
  end

  // Stage 1: input register
  always_ff @(posedge clk) begin
    if (rdy1) begin
      v1 <= in_data;
    end
  end

  assign vin[0] = v1.in_x;
  assign vin[1] = v1.in_y;
  assign vin[2] = v1.in_z;

  // Stage 2: split coordinates into signed upper and unsigned lower halves
  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int i = 0; i < 3; i++) begin
        hi2[i] <= vin[i][CW-1:HW];
        lo2[i] <= {1'b0, vin[i][HW-1:0]};
      end
    end
  end

  // Stage 3: matrix entry times each half
  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          ph3[j][i] <= mat[j][i] * hi2[i];
          pl3[j][i] <= mat[j][i] * lo2[i];
        end
      end
    end
  end

  // Stage 4: row sums of each half
  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int j = 0; j < 3; j++) begin
        sh4[j] <= SHW'(ph3[j][0]) + SHW'(ph3[j][1]) + SHW'(ph3[j][2]);
        sl4[j] <= SLW'(pl3[j][0]) + SLW'(pl3[j][1]) + SLW'(pl3[j][2]);
      end
    end
  end

  // Stage 5: join halves, round to Q16.16
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc[j] = (AW'(sh4[j]) <<< HW) + AW'(sl4[j]) + ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      for (int j = 0; j < 3; j++) begin
        r5[j] <= acc[j][AW-1:CW];
      end
    end
  end

  // Clip to 32 bits per axis
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      clipped[j] = !((&r5[j][RW-1:CW-1]) || !(|r5[j][RW-1:CW-1]));
      if (!clipped[j]) begin
        clip[j] = r5[j][CW-1:0];
      end else if (r5[j][RW-1]) begin
        clip[j] = COORD_MIN;
      end else begin
        clip[j] = COORD_MAX;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rdy_o) begin
      out_data.out_x     <= clip[0];
      out_data.out_y     <= clip[1];
      out_data.out_z     <= clip[2];
      out_data.saturated <= |clipped;
    end
  end

  // Some axis sits at a range limit
  assign at_limit = (out_data.out_x == COORD_MAX) || (out_data.out_x == COORD_MIN) ||
                    (out_data.out_y == COORD_MAX) || (out_data.out_y == COORD_MIN) ||
                    (out_data.out_z == COORD_MAX) || (out_data.out_z == COORD_MIN);

  // Every stage holds a point and the receiver stalls
  assign pipe_blocked = v1_valid && v2_valid && v3_valid && v4_valid && v5_valid &&
                        out_valid && out_stall;

  // Checks
  `QVR_ASSERT_NXT(a_accept_fills_s1, in_valid && !in_stall, v1_valid)
  `QVR_ASSERT_IMP(a_stall_only_when_full, in_stall, pipe_blocked)
  `QVR_ASSERT_NXT(a_s5_holds_on_block, v5_valid && !rdy_o, v5_valid)
  `QVR_ASSERT_IMP(a_sat_at_limit, out_valid && out_data.saturated, at_limit)

endmodule

`default_nettype wire
